// ===== rtl/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// olist_pkg: shared definitions of the ordered list engine
// Action and status codes, field widths and default parameter values.
// ----------------------------------------------------------------------------
package olist_pkg;

   localparam int DEFAULT_CAPACITY   = 64;
   localparam int DEFAULT_VALUE_BITS = 16;

   localparam int ACTION_BITS   = 3;
   localparam int FIELD_BITS    = 16;
   localparam int POSITION_BITS = 7;
   localparam int STATUS_BITS   = 2;
   localparam int COUNT_BITS    = 7;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_PREPEND = 3'd0,
      ACT_APPEND  = 3'd1,
      ACT_INSERT  = 3'd2,
      ACT_DELETE  = 3'd3,
      ACT_READ    = 3'd4
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK     = 2'd0,
      STAT_BADPOS = 2'd1,
      STAT_NOKEY  = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

endpackage

// ===== rtl/olist_ram.sv =====
// ----------------------------------------------------------------------------
// olist_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module olist_ram #(
   parameter int WIDTH = olist_pkg::DEFAULT_VALUE_BITS,
   parameter int DEPTH = olist_pkg::DEFAULT_CAPACITY
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine: ordered list of values held in a RAM
// A request transaction on req_ does push front, push back, insert at a
// 1-based position, delete the first entry equal to a key, or read the
// entry at a 0-based index. Each request yields one rsp_ transaction with
// the status, the entry count after the request and the value read.
// The entries live in one RAM; a small sequencer walks it through one
// shared index counter, moving or comparing one entry per cycle.
// req_ready is high only while the sequencer is idle. A rejected request
// goes straight to the response; an insert first moves the entries behind
// the position, a read fetches its entry, and a delete scans up to the
// match, or all entries when none matches, and moves the entries behind it.
// req_ready rises again in the same cycle as rsp_valid.
// The result is held in an output register; a stalled receiver holds it
// there, and a new request is worked on meanwhile, waiting to finish
// until the register is free.
// Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
   parameter int CAPACITY   = olist_pkg::DEFAULT_CAPACITY,
   parameter int VALUE_BITS = olist_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [olist_pkg::ACTION_BITS-1:0]   req_action,
   input  logic [olist_pkg::FIELD_BITS-1:0]    req_value,
   input  logic [olist_pkg::POSITION_BITS-1:0] req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [olist_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [olist_pkg::COUNT_BITS-1:0]    rsp_entry_count,
   output logic [olist_pkg::FIELD_BITS-1:0]    rsp_read_value
);

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = ((LW > olist_pkg::POSITION_BITS) ? LW : olist_pkg::POSITION_BITS) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_PLACE,
      S_SCAN,
      S_SHIFT_DN,
      S_FLUSH,
      S_READ,
      S_RESP
   } state_type;

   state_type                           state_ff, state_in;
   logic [LW-1:0]                       length_ff, length_in;
   logic [LW-1:0]                       cur_ff, cur_in;
   logic [LW-1:0]                       idx_ff, idx_in;
   logic [VALUE_BITS-1:0]               key_ff, key_in;
   logic                                pend_ff, pend_in;
   logic [AW-1:0]                       pend_addr_ff, pend_addr_in;
   logic                                chk_valid_ff, chk_valid_in;
   logic [AW-1:0]                       chk_idx_ff, chk_idx_in;
   olist_pkg::status_type               status_ff, status_in;
   logic [olist_pkg::FIELD_BITS-1:0]    rd_ff, rd_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [olist_pkg::STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [olist_pkg::COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;
   logic [olist_pkg::FIELD_BITS-1:0]    rsp_read_ff, rsp_read_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [VALUE_BITS-1:0] ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [VALUE_BITS-1:0] ram_rdata;
   logic                  full;
   logic [CW-1:0]         pos_wide;
   logic [CW-1:0]         len_wide;

   olist_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign full     = (length_ff == LW'(CAPACITY));
   assign pos_wide = CW'(req_position);
   assign len_wide = CW'(length_ff);

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_read_value  = rsp_read_ff;

   always_comb begin
      state_in      = state_ff;
      length_in     = length_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      status_in     = status_ff;
      rd_in         = rd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_read_in   = rsp_read_ff;
      ram_raddr     = AW'(cur_ff);

      // A pending move always owns the write port.
      if (pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = pend_addr_ff;
         ram_wdata = ram_rdata;
      end else begin
         ram_we    = (state_ff == S_PLACE);
         ram_waddr = AW'(idx_ff);
         ram_wdata = key_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in    = VALUE_BITS'(req_value);
               rd_in     = '0;
               status_in = olist_pkg::STAT_OK;
               state_in  = S_RESP;
               case (olist_pkg::action_type'(req_action))
                  olist_pkg::ACT_PREPEND: begin
                     if (full) begin
                        status_in = olist_pkg::STAT_FULL;
                     end else begin
                        idx_in   = '0;
                        cur_in   = length_ff;
                        state_in = S_SHIFT_UP;
                     end
                  end
                  olist_pkg::ACT_APPEND: begin
                     if (full) begin
                        status_in = olist_pkg::STAT_FULL;
                     end else begin
                        idx_in   = length_ff;
                        cur_in   = length_ff;
                        state_in = S_SHIFT_UP;
                     end
                  end
                  olist_pkg::ACT_INSERT: begin
                     if (pos_wide == '0 || pos_wide > len_wide + CW'(1)) begin
                        status_in = olist_pkg::STAT_BADPOS;
                     end else if (full) begin
                        status_in = olist_pkg::STAT_FULL;
                     end else begin
                        idx_in   = LW'(pos_wide - CW'(1));
                        cur_in   = length_ff;
                        state_in = S_SHIFT_UP;
                     end
                  end
                  olist_pkg::ACT_DELETE: begin
                     cur_in   = '0;
                     state_in = S_SCAN;
                  end
                  olist_pkg::ACT_READ: begin
                     if (pos_wide >= len_wide) begin
                        status_in = olist_pkg::STAT_BADPOS;
                     end else begin
                        ram_raddr = AW'(req_position);
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     status_in = olist_pkg::STAT_BADPOS;
                  end
               endcase
            end
         end
         S_SHIFT_UP: begin
            if (cur_ff > idx_ff) begin
               ram_raddr    = AW'(cur_ff - LW'(1));
               pend_in      = 1'b1;
               pend_addr_in = AW'(cur_ff);
               cur_in       = cur_ff - LW'(1);
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            if (!pend_ff) begin
               length_in = length_ff + LW'(1);
               state_in  = S_RESP;
            end
         end
         S_SCAN: begin
            if (chk_valid_ff && ram_rdata == key_ff) begin
               cur_in   = LW'(chk_idx_ff);
               state_in = S_SHIFT_DN;
            end else if (cur_ff < length_ff) begin
               ram_raddr    = AW'(cur_ff);
               chk_valid_in = 1'b1;
               chk_idx_in   = AW'(cur_ff);
               cur_in       = cur_ff + LW'(1);
            end else if (!chk_valid_ff) begin
               status_in = olist_pkg::STAT_NOKEY;
               state_in  = S_RESP;
            end
         end
         S_SHIFT_DN: begin
            if ((cur_ff + LW'(1)) < length_ff) begin
               ram_raddr    = AW'(cur_ff + LW'(1));
               pend_in      = 1'b1;
               pend_addr_in = AW'(cur_ff);
               cur_in       = cur_ff + LW'(1);
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!pend_ff) begin
               length_in = length_ff - LW'(1);
               state_in  = S_RESP;
            end
         end
         S_READ: begin
            rd_in    = olist_pkg::FIELD_BITS'(ram_rdata);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = olist_pkg::COUNT_BITS'(length_ff);
               rsp_read_in   = rd_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      pend_addr_ff  <= pend_addr_in;
      chk_idx_ff    <= chk_idx_in;
      status_ff     <= status_in;
      rd_ff         <= rd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_read_ff   <= rsp_read_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= '0;
         pend_ff      <= 1'b0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         pend_ff      <= pend_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
